FILE: src/wrtqs_pkg.sv
// Package: shared types, constants and codes of the three queue scheduler.
`default_nettype none
package wrtqs_pkg;
   localparam int QueueDepthDefault = 64;
   localparam int PidBitsDefault    = 16;
   localparam int LevelCount        = 3;
   localparam int LevelBits         = 2;

   localparam logic [4:0] LowLimitReset = 5'd3;
   localparam logic [4:0] MidLimitReset = 5'd9;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_PICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_REDRAW   = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   localparam logic [1:0] LVL_LOW  = 2'd0;
   localparam logic [1:0] LVL_MID  = 2'd1;
   localparam logic [1:0] LVL_HIGH = 2'd2;

   localparam logic CSR_LOW_LIMIT = 1'b0;
   localparam logic CSR_MID_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] process_id;
      logic [1:0]  priority_level;
      logic [4:0]  random_draw;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] chosen_pid;
      logic [1:0]  chosen_level;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESP
   } state_type;

   function automatic logic [1:0] level_of(input logic [1:0] code);
      logic [1:0] r;
      begin
         case (code)
            2'd0:    r = LVL_LOW;
            2'd1:    r = LVL_MID;
            default: r = LVL_HIGH;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

FILE: src/wrtqs_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module wrtqs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: src/wrtqs_ctrl.sv
// Sequencer: add, remove search with compaction, and pick over one queue RAM.
`default_nettype none
module wrtqs_ctrl
   import wrtqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int PID_BITS    = PidBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data,
   input  wire logic [4:0]  low_limit,
   input  wire logic [4:0]  mid_limit
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = AW + LevelBits;
   localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff [LevelCount];
   logic [CW-1:0] cnt_in [LevelCount];
   logic [1:0]    lvl_ff, lvl_in;
   logic [PID_BITS-1:0] pid_ff, pid_in;
   logic [CW-1:0] idx_ff, idx_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rvalid_ff, rvalid_in;

   logic          wr_en;
   logic [RW-1:0] wr_addr, rd_addr;
   logic [PID_BITS-1:0] wr_data, rd_data;

   wrtqs_ram #(.WIDTH(PID_BITS), .DEPTH(LevelCount * (1 << AW))) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

   logic [1:0]    req_lvl, pick_lvl;
   logic [CW-1:0] cur_cnt;
   logic [PID_BITS-1:0] req_pid;

   always_comb begin
      logic [AW-1:0] ia;
      req_lvl = level_of(req_data.priority_level);
      req_pid = PID_BITS'(req_data.process_id);
      if (req_data.random_draw <= low_limit) begin
         pick_lvl = LVL_LOW;
      end else if (req_data.random_draw <= mid_limit) begin
         pick_lvl = LVL_MID;
      end else begin
         pick_lvl = LVL_HIGH;
      end
      cur_cnt = cnt_ff[lvl_ff];
      ia = idx_ff[AW-1:0];

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lvl_in    = lvl_ff;
      pid_in    = pid_ff;
      idx_in    = idx_ff;
      rsp_in    = rsp_ff;
      rvalid_in = rvalid_ff;
      wr_en     = 1'b0;
      wr_addr   = {lvl_ff, ia};
      wr_data   = pid_ff;
      rd_addr   = {lvl_ff, ia};

      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in = '0;
               case (cmd_type'(req_data.command))
                  CMD_ADD: begin
                     rsp_in.chosen_level = req_lvl;
                     if (cnt_ff[req_lvl] >= Full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = {req_lvl, cnt_ff[req_lvl][AW-1:0]};
                        wr_data = req_pid;
                        cnt_in[req_lvl] = cnt_ff[req_lvl] + 1'b1;
                        rsp_in.status = ST_DONE;
                     end
                     rvalid_in = 1'b1;
                  end
                  CMD_REMOVE: begin
                     lvl_in = req_lvl;
                     pid_in = req_pid;
                     idx_in = '0;
                     rd_addr = {req_lvl, {AW{1'b0}}};
                     rsp_in.chosen_level = req_lvl;
                     if (cnt_ff[req_lvl] == '0) begin
                        rsp_in.status = ST_NOTFOUND;
                        rvalid_in = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_PICK: begin
                     if (cnt_ff[0] == '0 && cnt_ff[1] == '0 && cnt_ff[2] == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rvalid_in = 1'b1;
                     end else if (cnt_ff[pick_lvl] == '0) begin
                        rsp_in.status = ST_REDRAW;
                        rsp_in.chosen_level = pick_lvl;
                        rvalid_in = 1'b1;
                     end else begin
                        // head read now; shift the tail down behind it
                        rsp_in.chosen_level = pick_lvl;
                        rsp_in.status = ST_DONE;
                        lvl_in  = pick_lvl;
                        idx_in  = '0;
                        rd_addr = {pick_lvl, {AW{1'b0}}};
                        pid_in  = '0;
                        state_in = S_RESP;
                     end
                  end
                  default: rvalid_in = 1'b1;
               endcase
            end
         end
         S_RESP: begin
            // head data available: latch it, then compact
            rsp_in.chosen_pid = 16'(rd_data);
            state_in = S_SHIFT_RD;
            idx_in   = idx_ff + 1'b1;
            rd_addr  = {lvl_ff, ia + 1'b1};
         end
         S_SEARCH: begin
            // rd_data holds entry idx
            if (rd_data == pid_ff) begin
               rsp_in.status = ST_DONE;
               state_in = S_SHIFT_RD;
               idx_in   = idx_ff + 1'b1;
               rd_addr  = {lvl_ff, ia + 1'b1};
            end else if (idx_ff + 1'b1 >= cur_cnt) begin
               rsp_in.status = ST_NOTFOUND;
               rvalid_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = {lvl_ff, ia + 1'b1};
            end
         end
         S_SHIFT_RD: begin
            // idx points at source entry being read
            if (idx_ff >= cur_cnt) begin
               cnt_in[lvl_ff] = cur_cnt - 1'b1;
               rvalid_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = {lvl_ff, ia - 1'b1};
            wr_data = rd_data;
            idx_in  = idx_ff + 1'b1;
            rd_addr = {lvl_ff, ia + 1'b1};
            state_in = S_SHIFT_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < LevelCount; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         cnt_ff    <= cnt_in;
      end
      lvl_ff <= lvl_in;
      pid_ff <= pid_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

FILE: src/weighted_random_three_queue_scheduler_unit.sv
// Top level of the three queue weighted random scheduler.
//
// Usage: req_ carries commands (add, remove, pick) as one transfer each; every
// command gives exactly one rsp_ transfer. csr_ writes the two draw limits
// (index 0 low limit, index 1 middle limit) while the block is idle.
// All three queues share one RAM with a registered read, one region
// per priority level.
// An add or an early-out result raises rsp_valid in the cycle after it is
// taken. Pick pops the head and compacts the queue. Remove reads entries one
// per cycle until a match, then moves each later entry down, reading it in
// S_SHIFT_RD and writing it one slot lower in S_SHIFT_WR; the worst case is a
// match at the head of a full queue. The RAM read port paces these steps.
// One command is in work at a time; req_ready stays low until its transfer
// on rsp_ leaves, so a stalled receiver holds the block.
// Reset clears the counts and sets the limits to their reset values at once; no
// clearing pass is needed since only entries below the count are used.
`default_nettype none
module weighted_random_three_queue_scheduler_unit
   import wrtqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int PID_BITS    = PidBitsDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      rsp_type    rsp_data,
   input  wire logic       csr_write,
   input  wire logic       csr_index,
   input  wire logic [4:0] csr_wdata
);
   logic [4:0] low_limit_ff, mid_limit_ff;

   // hold limits; the user must write them only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff <= LowLimitReset;
         mid_limit_ff <= MidLimitReset;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOW_LIMIT: low_limit_ff <= csr_wdata;
            CSR_MID_LIMIT: mid_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   wrtqs_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .PID_BITS(PID_BITS)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .low_limit(low_limit_ff),
      .mid_limit(mid_limit_ff)
   );
endmodule
`default_nettype wire

FILE: src/wrtqs_checker.sv
// Port checker for the scheduler, bound to the top level.
`default_nettype none
module wrtqs_checker
   import wrtqs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result waits");
   a_pid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.chosen_pid == '0)
      else $error("pid on a non-done result");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request before result");
endmodule

bind weighted_random_three_queue_scheduler_unit wrtqs_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the three queue weighted random scheduler: random and directed commands.
`default_nettype none
module tb;
   import wrtqs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 64;

   // Scoreboard: shadow queues, draw limits and pending responses.
   class sched_scoreboard;
      logic [15:0] lvl_q[3][$];
      logic [4:0]  low_lim, mid_lim;
      rsp_type     pending[$];
      int          mismatches;

      function void clear();
         for (int i = 0; i < 3; i++) lvl_q[i].delete();
         low_lim = LowLimitReset;
         mid_lim = MidLimitReset;
         pending.delete();
         mismatches = 0;
      endfunction

      function int count(int l);
         return lvl_q[l].size();
      endfunction

      // Predict the response of one accepted command.
      function void note_command(req_type r);
         rsp_type e;
         int l, sel;
         bit found;
         e = '0;
         l = int'(level_of(r.priority_level));
         case (cmd_type'(r.command))
            CMD_ADD: begin
               e.chosen_level = l[1:0];
               if (lvl_q[l].size() >= Depth) begin
                  e.status = ST_FULL;
               end else begin
                  lvl_q[l].push_back(r.process_id);
                  e.status = ST_DONE;
               end
            end
            CMD_REMOVE: begin
               e.chosen_level = l[1:0];
               found = 0;
               for (int i = 0; i < lvl_q[l].size(); i++) begin
                  if (lvl_q[l][i] == r.process_id) begin
                     lvl_q[l].delete(i);
                     found = 1;
                     break;
                  end
               end
               e.status = found ? ST_DONE : ST_NOTFOUND;
            end
            CMD_PICK: begin
               if (lvl_q[0].size() == 0 && lvl_q[1].size() == 0 && lvl_q[2].size() == 0) begin
                  e.status = ST_EMPTY;
               end else begin
                  if (r.random_draw <= low_lim) sel = 0;
                  else if (r.random_draw <= mid_lim) sel = 1;
                  else sel = 2;
                  e.chosen_level = sel[1:0];
                  if (lvl_q[sel].size() == 0) begin
                     e.status = ST_REDRAW;
                  end else begin
                     e.status = ST_DONE;
                     e.chosen_pid = lvl_q[sel].pop_front();
                  end
               end
            end
            default: e.status = ST_DONE;
         endcase
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", a);
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status || a.chosen_pid !== e.chosen_pid ||
             a.chosen_level !== e.chosen_level) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp st=%0d pid=%h lvl=%0d got st=%0d pid=%h lvl=%0d",
                        e.status, e.chosen_pid, e.chosen_level,
                        a.status, a.chosen_pid, a.chosen_level);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_write, csr_index;
   logic [4:0] csr_wdata;

   int send_idle_pct, recv_idle_pct;
   sched_scoreboard sb;

   weighted_random_three_queue_scheduler_unit i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write, .csr_index, .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: a hung handshake must not run forever.
   initial begin
      #40ms;
      $display("weighted_random_three_queue_scheduler_unit verification failed");
      $finish;
   end

   // Receiver: stall at random, check every response transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Drive one command; hold valid and payload until the transfer happens.
   task automatic send_command(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_command(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_limit(input logic idx, input logic [4:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_LOW_LIMIT) sb.low_lim = val;
      else sb.mid_lim = val;
      @(posedge clock);
   endtask

   function automatic req_type make_cmd(cmd_type c, logic [15:0] pid, logic [1:0] pr,
                                        logic [4:0] dr);
      req_type r;
      r.command = c;
      r.process_id = pid;
      r.priority_level = pr;
      r.random_draw = dr;
      return r;
   endfunction

   // Random command, weighted so queues fill and drain; remove often hits a live pid.
   function automatic req_type random_cmd();
      int k, l;
      logic [15:0] pid;
      k = $urandom_range(99);
      l = $urandom_range(3);
      pid = 16'($urandom);
      if ($urandom_range(1) == 1) pid = pid & 16'h000f;
      if (k < 40) return make_cmd(CMD_ADD, pid, l[1:0], 5'($urandom));
      if (k < 60) begin
         l = int'(level_of(l[1:0]));
         if (sb.count(l) != 0 && $urandom_range(3) != 0)
            pid = sb.lvl_q[l][$urandom_range(sb.count(l) - 1)];
         return make_cmd(CMD_REMOVE, pid, l[1:0], 5'($urandom));
      end
      if (k < 97)
         return make_cmd(CMD_PICK, pid, 2'($urandom), 5'($urandom_range(18)));
      if (k < 99)
         return make_cmd(CMD_PICK, pid, 2'($urandom), 5'($urandom_range(31, 19)));
      return make_cmd(CMD_NONE, pid, 2'($urandom), 5'($urandom));
   endfunction

   initial begin
      logic [4:0] lo, mi;
      sb = new();
      sb.clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 19;
      recv_idle_pct = 76;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pick, extremes of fields, full queue, missing pid, code three.
      send_command(make_cmd(CMD_PICK, 16'hffff, 2'd3, 5'd0));
      send_command(make_cmd(CMD_REMOVE, 16'h1234, 2'd0, 5'd0));
      send_command(make_cmd(CMD_ADD, 16'hffff, 2'd3, 5'd31));
      send_command(make_cmd(CMD_ADD, 16'h0000, 2'd0, 5'd0));
      send_command(make_cmd(CMD_PICK, 16'h0, 2'd0, 5'd5));
      send_command(make_cmd(CMD_PICK, 16'h0, 2'd0, 5'd31));
      send_command(make_cmd(CMD_REMOVE, 16'hffff, 2'd3, 5'd0));
      send_command(make_cmd(CMD_NONE, 16'hffff, 2'd3, 5'd31));
      for (int i = 0; i < Depth + 1; i++)
         send_command(make_cmd(CMD_ADD, 16'(i * 977), 2'd1, 5'd0));
      send_command(make_cmd(CMD_REMOVE, 16'(63 * 977), 2'd1, 5'd0));
      send_command(make_cmd(CMD_REMOVE, 16'h0000, 2'd1, 5'd0));
      send_command(make_cmd(CMD_REMOVE, 16'h0001, 2'd1, 5'd0));
      // Pause until every expected response is back.
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin lo = 5'd0;  mi = 5'd18; end
            1: begin lo = 5'd18; mi = 5'd18; end
            2: begin lo = 5'd31; mi = 5'd0;  end
            3: begin lo = 5'd0;  mi = 5'd0;  end
            default: begin
               lo = 5'($urandom_range(18));
               mi = 5'($urandom_range(18));
            end
         endcase
         write_limit(CSR_LOW_LIMIT, lo);
         write_limit(CSR_MID_LIMIT, mi);
         if (ph == 2) begin send_idle_pct = 76; recv_idle_pct = 19; end
         if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
         for (int n = 0; n < 280; n++) send_command(random_cmd());
         drain();
      end

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("weighted_random_three_queue_scheduler_unit verification clean");
      else
         $display("weighted_random_three_queue_scheduler_unit verification failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
src/wrtqs_pkg.sv
src/wrtqs_ram.sv
src/wrtqs_ctrl.sv
src/weighted_random_three_queue_scheduler_unit.sv
src/wrtqs_checker.sv
tb/tb.sv
